[src/mcbq_pkg.sv]
// shared types and constants for the multi-channel bounded queue
`default_nettype none
package mcbq_pkg;
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_OPEN      = 3'd0,
    OP_CLOSE     = 3'd1,
    OP_SEND      = 3'd2,
    OP_RECEIVE   = 3'd3,
    OP_BROADCAST = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_CHANNEL  = 2'd1,
    ST_WOULD_BLOCK = 2'd2,
    ST_NO_SLOT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH,
    S_READ,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

[src/mcbq_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module mcbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/multi_channel_bounded_queue.sv]
// multi-channel bounded queue top level
//
// One input channel (opcode, channel_id, send_word, fill_limit) and one
// output channel (status, opened_id, recv_word), each with valid/ready.
// Every input transaction yields exactly one result transaction.
// The block takes one transaction at a time; in_ready is low while it works.
// Close, send and invalid opcodes go from scan to done; receive also
// passes a read state (store read is registered). Open and broadcast walk
// the channel slots one per cycle through a single compare unit: open
// stops at the first free slot or the last; broadcast checks every slot,
// then re-walks them to append, since the shared store has one write port.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its done state without losing the result.
// Reset clears all channel state at once; the message store needs no
// clearing since only written entries are ever read.
`default_nettype none
module multi_channel_bounded_queue
  import mcbq_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [2:0]  channel_id,
  input  wire logic [31:0] send_word,
  input  wire logic [4:0]  fill_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [2:0]       opened_id,
  output logic [31:0]      recv_word
);
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int SD = NUM_CHANNELS * DEPTH;
  localparam int AW = (SD > 1) ? $clog2(SD) : 1;

  state_t state, state_next;

  logic [NUM_CHANNELS-1:0] slot_open;
  logic [NW-1:0] slot_limit [NUM_CHANNELS];
  logic [NW-1:0] slot_count [NUM_CHANNELS];
  logic [HW-1:0] slot_head  [NUM_CHANNELS];

  logic [2:0]  op;
  logic [2:0]  cid;
  logic [31:0] word;
  logic [NW-1:0] lim;
  logic [CW-1:0] idx;
  logic seen_open, any_full, pushing;

  logic [1:0]  status_r;
  logic [2:0]  opened_r;
  logic [31:0] rword_r;
  logic        rsel;

  // store port
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   rdata;

  mcbq_ram #(.WIDTH(32), .DEPTH(SD)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(word), .rdata(rdata)
  );

  // single compare unit on the selected slot
  logic [CW-1:0] sel;
  logic          sel_ok;
  logic          sel_full;
  logic [HW-1:0] tail;
  logic [HW:0]   tail_sum;
  logic          cid_in_range;

  always_comb begin
    cid_in_range = ({29'd0, cid} < 32'(NUM_CHANNELS));
    sel = (state == S_IDLE) ? channel_id[CW-1:0] :
          ((op == OP_SEND || op == OP_RECEIVE || op == OP_CLOSE) ? cid[CW-1:0] : idx);
    if (state == S_IDLE) cid_in_range = ({29'd0, channel_id} < 32'(NUM_CHANNELS));
    sel_ok   = slot_open[sel];
    sel_full = (slot_count[sel] >= slot_limit[sel]);
    tail_sum = {1'b0, slot_head[sel]} + (HW + 1)'(slot_count[sel]);
    if (DEPTH == (1 << HW)) tail = tail_sum[HW-1:0];
    else tail = (tail_sum >= (HW + 1)'(DEPTH)) ? HW'(tail_sum - (HW + 1)'(DEPTH))
                                                : tail_sum[HW-1:0];
  end

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_DONE);
  assign status    = status_r;
  assign opened_id = opened_r;
  assign recv_word = rsel ? rword_r : 32'd0;

  logic last;
  assign last = ({{(32-CW){1'b0}}, idx} == 32'(NUM_CHANNELS - 1));

  always_comb begin
    state_next = state;
    we = 1'b0;
    addr = AW'(sel) * AW'(DEPTH) + AW'(pushing ? tail : slot_head[sel]);
    case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: begin
        case (op)
          OP_OPEN:      if (!sel_ok || last) state_next = S_DONE;
          OP_SEND:      begin
            we = cid_in_range && sel_ok && !sel_full;
            state_next = S_DONE;
          end
          OP_RECEIVE:   state_next = (cid_in_range && sel_ok && slot_count[sel] != '0)
                                     ? S_READ : S_DONE;
          OP_BROADCAST: if (last) state_next = (any_full || (sel_ok && sel_full) ||
                                   !(seen_open || sel_ok)) ? S_DONE : S_PUSH;
          default:      state_next = S_DONE;
        endcase
      end
      S_PUSH: begin
        we = sel_ok;
        if (last) state_next = S_DONE;
      end
      S_READ: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign pushing = (state == S_PUSH) || (state == S_SCAN && op == OP_SEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_open <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        slot_limit[i] <= '0;
        slot_count[i] <= '0;
        slot_head[i]  <= '0;
      end
      idx <= '0;
      seen_open <= 1'b0;
      any_full <= 1'b0;
      rsel <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          op <= opcode;
          cid <= channel_id;
          word <= send_word;
          lim <= (32'(fill_limit) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(fill_limit);
          idx <= '0;
          seen_open <= 1'b0;
          any_full <= 1'b0;
          rsel <= 1'b0;
          status_r <= ST_OK;
          opened_r <= 3'd0;
        end
        S_SCAN: begin
          case (op)
            OP_OPEN: begin
              if (!sel_ok) begin
                slot_open[sel] <= 1'b1;
                slot_limit[sel] <= lim;
                slot_count[sel] <= '0;
                slot_head[sel] <= '0;
                opened_r <= 3'(sel);
              end else if (last) begin
                status_r <= ST_NO_SLOT;
              end
              idx <= idx + 1'b1;
            end
            OP_CLOSE: if (cid_in_range && sel_ok) begin
              slot_open[sel] <= 1'b0;
              slot_count[sel] <= '0;
              slot_head[sel] <= '0;
            end
            OP_SEND: begin
              if (!(cid_in_range && sel_ok)) status_r <= ST_NO_CHANNEL;
              else if (sel_full) status_r <= ST_WOULD_BLOCK;
              else slot_count[sel] <= slot_count[sel] + 1'b1;
            end
            OP_RECEIVE: begin
              if (!(cid_in_range && sel_ok)) status_r <= ST_NO_CHANNEL;
              else if (slot_count[sel] == '0) status_r <= ST_WOULD_BLOCK;
              else begin
                rsel <= 1'b1;
                slot_count[sel] <= slot_count[sel] - 1'b1;
                if (32'(slot_head[sel]) == 32'(DEPTH - 1)) slot_head[sel] <= '0;
                else slot_head[sel] <= slot_head[sel] + 1'b1;
              end
            end
            OP_BROADCAST: begin
              seen_open <= seen_open | sel_ok;
              any_full <= any_full | (sel_ok & sel_full);
              if (last) begin
                idx <= '0;
                if (any_full || (sel_ok && sel_full)) status_r <= ST_WOULD_BLOCK;
                else if (!(seen_open || sel_ok)) status_r <= ST_NO_CHANNEL;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_PUSH: begin
          if (sel_ok) slot_count[sel] <= slot_count[sel] + 1'b1;
          idx <= idx + 1'b1;
        end
        S_READ: rword_r <= rdata;
        default: ;
      endcase
    end
  end

  // result is held while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(recv_word))
    else $error("result changed under stall");
  // no new transaction while one is in flight
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input and output both open");
  // a successful open leaves the reported slot open
  assert property (@(posedge clk) disable iff (rst)
    out_valid && op == OP_OPEN && status == ST_OK |-> slot_open[opened_id[CW-1:0]])
    else $error("opened slot not open");
  // receive word only on ok status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> recv_word == 32'd0)
    else $error("word with error status");
endmodule
`default_nettype wire

[dv/multi_channel_bounded_queue_tb.sv]
// testbench for the multi-channel bounded queue: directed table plus random traffic
`timescale 1ns / 100ps
`default_nettype none
module multi_channel_bounded_queue_tb;
  import mcbq_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int DEP = DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  st;
    logic [2:0]  oid;
    logic [31:0] word;
  } reply_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  ch;
    logic [31:0] word;
    logic [4:0]  lim;
    logic        known;
    reply_t      rep;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic [2:0] channel_id = '0;
  logic [31:0] send_word = '0;
  logic [4:0] fill_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [2:0] opened_id;
  logic [31:0] recv_word;

  multi_channel_bounded_queue dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .channel_id(channel_id), .send_word(send_word),
    .fill_limit(fill_limit), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .opened_id(opened_id), .recv_word(recv_word)
  );

  always #5 clk = ~clk;

  // queue state mirror
  logic        ch_open [NCH];
  int unsigned ch_limit [NCH];
  int unsigned ch_count [NCH];
  int unsigned ch_head [NCH];
  logic [31:0] ch_words [NCH*DEP];

  reply_t pending_replies[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic reply_t queue_apply(logic [2:0] op, logic [2:0] ch,
                                         logic [31:0] w, logic [4:0] lim);
    reply_t r;
    logic seen_open;
    logic any_full;
    r = '{st: ST_OK, oid: '0, word: '0};
    seen_open = 1'b0;
    any_full = 1'b0;
    case (op)
      OP_OPEN: begin
        r.st = ST_NO_SLOT;
        for (int i = 0; i < NCH; i++) begin
          if (!ch_open[i] && r.st == ST_NO_SLOT) begin
            ch_open[i] = 1'b1;
            ch_limit[i] = (lim > DEP) ? DEP : lim;
            ch_count[i] = 0;
            ch_head[i] = 0;
            r.oid = i[2:0];
            r.st = ST_OK;
          end
        end
      end
      OP_CLOSE: begin
        if (ch_open[ch]) begin
          ch_open[ch] = 1'b0;
          ch_count[ch] = 0;
          ch_head[ch] = 0;
        end
      end
      OP_SEND: begin
        if (!ch_open[ch]) r.st = ST_NO_CHANNEL;
        else if (ch_count[ch] >= ch_limit[ch]) r.st = ST_WOULD_BLOCK;
        else begin
          ch_words[ch*DEP + (ch_head[ch] + ch_count[ch]) % DEP] = w;
          ch_count[ch]++;
        end
      end
      OP_RECEIVE: begin
        if (!ch_open[ch]) r.st = ST_NO_CHANNEL;
        else if (ch_count[ch] == 0) r.st = ST_WOULD_BLOCK;
        else begin
          r.word = ch_words[ch*DEP + ch_head[ch]];
          ch_head[ch] = (ch_head[ch] + 1) % DEP;
          ch_count[ch]--;
        end
      end
      OP_BROADCAST: begin
        for (int i = 0; i < NCH; i++) begin
          if (ch_open[i]) begin
            seen_open = 1'b1;
            if (ch_count[i] >= ch_limit[i]) any_full = 1'b1;
          end
        end
        if (any_full) r.st = ST_WOULD_BLOCK;
        else if (!seen_open) r.st = ST_NO_CHANNEL;
        else begin
          for (int i = 0; i < NCH; i++) begin
            if (ch_open[i]) begin
              ch_words[i*DEP + (ch_head[i] + ch_count[i]) % DEP] = w;
              ch_count[i]++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(logic [2:0] op, logic [2:0] ch, logic [31:0] w,
                       logic [4:0] lim, logic known, reply_t typed);
    reply_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = queue_apply(op, ch, w, lim);
    if (known && r != typed) begin
      $display("%0t table row wrong: expected %h got %h", $time, typed, r);
      errors++;
    end
    pending_replies.push_back(r);
    in_valid <= 1'b1;
    opcode <= op;
    channel_id <= ch;
    send_word <= w;
    fill_limit <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t unexpected result st=%0d id=%0d w=%h", $time, status, opened_id,
                   recv_word);
          errors++;
        end else begin
          reply_t e;
          e = pending_replies.pop_front();
          if (status !== e.st) begin
            $display("%0t status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (opened_id !== e.oid) begin
            $display("%0t opened_id expected %0d actual %0d", $time, e.oid, opened_id);
            errors++;
          end
          if (recv_word !== e.word) begin
            $display("%0t recv_word expected %h actual %h", $time, e.word, recv_word);
            errors++;
          end
        end
      end
      out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end
  end

  // choose a random transaction, mostly on open channels
  task automatic random_item();
    logic [2:0] op;
    logic [2:0] ch;
    int k;
    k = $urandom_range(99);
    if (k < 8) op = OP_OPEN;
    else if (k < 14) op = OP_CLOSE;
    else if (k < 50) op = OP_SEND;
    else if (k < 84) op = OP_RECEIVE;
    else if (k < 97) op = OP_BROADCAST;
    else op = 3'($urandom_range(7, 5));
    ch = 3'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      for (int t = 0; t < 4; t++) if (!ch_open[ch]) ch = 3'($urandom_range(7));
    end
    issue(op, ch, $urandom, ($urandom_range(3) == 0) ? 5'($urandom_range(31))
          : 5'($urandom_range(6, 1)), 1'b0, '0);
  endtask

  row_t dir_rows[$];

  initial begin
    for (int i = 0; i < NCH; i++) begin
      ch_open[i] = 1'b0;
      ch_limit[i] = 0;
      ch_count[i] = 0;
      ch_head[i] = 0;
    end
    // op, ch, word, lim, known, reply
    dir_rows = '{
      '{OP_SEND,      3'd0, 32'h1,          5'd0,  1'b1, '{ST_NO_CHANNEL, 3'd0, 32'h0}},
      '{OP_RECEIVE,   3'd7, 32'h0,          5'd0,  1'b1, '{ST_NO_CHANNEL, 3'd0, 32'h0}},
      '{OP_BROADCAST, 3'd0, 32'h5,          5'd0,  1'b1, '{ST_NO_CHANNEL, 3'd0, 32'h0}},
      '{OP_CLOSE,     3'd3, 32'h0,          5'd0,  1'b1, '{ST_OK, 3'd0, 32'h0}},
      '{3'd7,         3'd7, 32'hffffffff,   5'd31, 1'b1, '{ST_OK, 3'd0, 32'h0}},
      '{OP_OPEN,      3'd0, 32'h0,          5'd31, 1'b1, '{ST_OK, 3'd0, 32'h0}},
      '{OP_OPEN,      3'd0, 32'h0,          5'd0,  1'b1, '{ST_OK, 3'd1, 32'h0}},
      '{OP_SEND,      3'd1, 32'h2,          5'd0,  1'b1, '{ST_WOULD_BLOCK, 3'd0, 32'h0}},
      '{OP_BROADCAST, 3'd0, 32'h3,          5'd0,  1'b1, '{ST_WOULD_BLOCK, 3'd0, 32'h0}},
      '{OP_CLOSE,     3'd1, 32'h0,          5'd0,  1'b1, '{ST_OK, 3'd0, 32'h0}},
      '{OP_SEND,      3'd0, 32'hffffffff,   5'd0,  1'b1, '{ST_OK, 3'd0, 32'h0}},
      '{OP_RECEIVE,   3'd0, 32'h0,          5'd0,  1'b1, '{ST_OK, 3'd0, 32'hffffffff}},
      '{OP_RECEIVE,   3'd0, 32'h0,          5'd0,  1'b1, '{ST_WOULD_BLOCK, 3'd0, 32'h0}},
      '{OP_OPEN,      3'd0, 32'h0,          5'd16, 1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd1,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd2,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd3,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd4,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd5,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd6,  1'b0, '0},
      '{OP_OPEN,      3'd0, 32'h0,          5'd7,  1'b1, '{ST_NO_SLOT, 3'd0, 32'h0}},
      '{OP_BROADCAST, 3'd0, 32'h5a5a5a5a,   5'd0,  1'b0, '0},
      '{OP_RECEIVE,   3'd6, 32'h0,          5'd0,  1'b0, '0},
      '{OP_SEND,      3'd2, 32'h0,          5'd0,  1'b0, '0},
      '{3'd5,         3'd0, 32'h0,          5'd0,  1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i])
      issue(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].word, dir_rows[i].lim,
            dir_rows[i].known, dir_rows[i].rep);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 51 : 0;
      recv_idle = (ph == 0) ? 51 : (ph == 1) ? 24 : 0;
      for (int n = 0; n < 575; n++) begin
        random_item();
        if (n == 300) drain();
      end
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
